/* hdl/rpw_pkg.sv */
// ----------------------------------------------------------------------------
// rpw_pkg
// Shared types, constants and register indexes for the rc pulse width
// capture block.
// ----------------------------------------------------------------------------
package rpw_pkg;

    // fixed field widths
    localparam int TIME_W    = 16;
    localparam int MASK_W    = 8;
    localparam int CH_W      = 3;
    localparam int ACT_W     = 3;
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 3;

    // parameter defaults
    localparam int CHANNELS_DEF   = 8;
    localparam int TIMER_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_ENABLE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMER_TOP       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROLL_CHANNEL    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_CHANNEL   = 3'd5;

    // register reset values
    localparam logic [MASK_W-1:0] ENABLE_RST = 8'hFF;
    localparam logic [TIME_W-1:0] TOP_RST    = 16'd4001;
    localparam logic [TIME_W-1:0] UPPER_RST  = 16'd3000;
    localparam logic [TIME_W-1:0] LOWER_RST  = 16'd2000;
    localparam logic [CH_W-1:0]   ROLL_RST   = 3'd0;
    localparam logic [CH_W-1:0]   PITCH_RST  = 3'd1;

    // stick action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LEFT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DOWN  = 3'd4;

    // edge event beat
    typedef struct packed {
        logic [TIME_W-1:0] timer_count;
        logic [MASK_W-1:0] pending_mask;
    } evt_t;

    // result beat
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] pulse_width;
        logic [ACT_W-1:0]  stick_action;
        logic              last;
    } res_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [TIME_W-1:0] timer_top;
        logic [TIME_W-1:0] upper_threshold;
        logic [TIME_W-1:0] lower_threshold;
        logic [CH_W-1:0]   roll_channel;
        logic [CH_W-1:0]   pitch_channel;
    } cfg_t;

endpackage

/* hdl/rpw_queue.sv */
// ----------------------------------------------------------------------------
// rpw_queue
// Small first-in first-out queue of edge events between front and back end.
// ----------------------------------------------------------------------------
module rpw_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = rpw_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hdl/rpw_front.sv */
// ----------------------------------------------------------------------------
// rpw_front
// Holds the configuration registers, takes edge event beats, drops channels
// that are disabled and queues events that touch at least one enabled channel.
// ----------------------------------------------------------------------------
module rpw_front #(
    parameter int CHANNELS   = rpw_pkg::CHANNELS_DEF,
    parameter int TIMER_BITS = rpw_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_valid,
    output logic                          evt_stall,
    input  rpw_pkg::evt_t                 evt,
    input  logic                          cfg_we,
    input  logic [rpw_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [rpw_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [((TIMER_BITS < rpw_pkg::TIME_W) ? TIMER_BITS : rpw_pkg::TIME_W)
                  + ((CHANNELS < rpw_pkg::MASK_W) ? CHANNELS : rpw_pkg::MASK_W)
                  - 1:0]              q_wdata,
    output rpw_pkg::cfg_t                 cfg
);

    localparam int NCH  = (CHANNELS < rpw_pkg::MASK_W) ? CHANNELS : rpw_pkg::MASK_W;
    localparam int TS_W = (TIMER_BITS < rpw_pkg::TIME_W) ? TIMER_BITS : rpw_pkg::TIME_W;

    logic [rpw_pkg::MASK_W-1:0] enable_reg;
    rpw_pkg::cfg_t              cfg_reg;
    logic [NCH-1:0]             masked;
    logic [TS_W-1:0]            now;

    // register writes, unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg              <= rpw_pkg::ENABLE_RST;
            cfg_reg.timer_top       <= rpw_pkg::TOP_RST;
            cfg_reg.upper_threshold <= rpw_pkg::UPPER_RST;
            cfg_reg.lower_threshold <= rpw_pkg::LOWER_RST;
            cfg_reg.roll_channel    <= rpw_pkg::ROLL_RST;
            cfg_reg.pitch_channel   <= rpw_pkg::PITCH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpw_pkg::REG_CHANNEL_ENABLE:
                    enable_reg <= cfg_data[rpw_pkg::MASK_W-1:0];
                rpw_pkg::REG_TIMER_TOP:
                    cfg_reg.timer_top <= cfg_data[rpw_pkg::TIME_W-1:0];
                rpw_pkg::REG_UPPER_THRESHOLD:
                    cfg_reg.upper_threshold <= cfg_data[rpw_pkg::TIME_W-1:0];
                rpw_pkg::REG_LOWER_THRESHOLD:
                    cfg_reg.lower_threshold <= cfg_data[rpw_pkg::TIME_W-1:0];
                rpw_pkg::REG_ROLL_CHANNEL:
                    cfg_reg.roll_channel <= cfg_data[rpw_pkg::CH_W-1:0];
                rpw_pkg::REG_PITCH_CHANNEL:
                    cfg_reg.pitch_channel <= cfg_data[rpw_pkg::CH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // classify: keep only enabled channels, skip events that touch none
    assign masked    = evt.pending_mask[NCH-1:0] & enable_reg[NCH-1:0];
    assign now       = evt.timer_count[TS_W-1:0];
    assign evt_stall = q_full;
    assign q_push    = evt_valid && !q_full && (masked != '0);
    assign q_wdata   = {now, masked};

endmodule

/* hdl/rpw_back.sv */
// ----------------------------------------------------------------------------
// rpw_back
// Keeps the per-channel edge phase, rise time and last width, works through an
// event's completing channels one per cycle unless stalled; decodes stick action.
// ----------------------------------------------------------------------------
module rpw_back #(
    parameter int CHANNELS   = rpw_pkg::CHANNELS_DEF,
    parameter int TIMER_BITS = rpw_pkg::TIMER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  logic [((TIMER_BITS < rpw_pkg::TIME_W) ? TIMER_BITS : rpw_pkg::TIME_W)
                  + ((CHANNELS < rpw_pkg::MASK_W) ? CHANNELS : rpw_pkg::MASK_W)
                  - 1:0]  q_rdata,
    output logic          q_pop,
    input  rpw_pkg::cfg_t cfg,
    output logic          res_valid,
    input  logic          res_stall,
    output rpw_pkg::res_t res
);

    localparam int NCH   = (CHANNELS < rpw_pkg::MASK_W) ? CHANNELS : rpw_pkg::MASK_W;
    localparam int TS_W  = (TIMER_BITS < rpw_pkg::TIME_W) ? TIMER_BITS : rpw_pkg::TIME_W;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [rpw_pkg::CH_W:0] NCH_V = (rpw_pkg::CH_W + 1)'(NCH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } bk_state_t;

    bk_state_t                  state_reg, state_next;
    logic [NCH-1:0]             af_reg;
    logic [NCH-1:0]             fall_reg;
    logic [TS_W-1:0]            now_reg;
    logic [TS_W-1:0]            rise_time_reg  [0:NCH-1];
    logic [rpw_pkg::TIME_W-1:0] last_width_reg [0:NCH-1];

    logic                       w_valid_reg;
    logic [rpw_pkg::CH_W-1:0]   w_ch_reg;
    logic [rpw_pkg::TIME_W-1:0] w_width_reg;
    logic                       w_last_reg;

    logic                       out_valid_reg;
    rpw_pkg::res_t              out_reg;

    logic [TS_W-1:0]            q_now;
    logic [NCH-1:0]             q_mask;
    logic                       load;
    logic                       w_move;
    logic                       advance;
    logic                       pick_fire;
    logic [IDX_W-1:0]           pick_idx;
    logic [NCH-1:0]             remaining;
    logic                       pick_last;
    logic [TS_W-1:0]            rise;
    logic [rpw_pkg::TIME_W-1:0] width;
    logic [rpw_pkg::TIME_W-1:0] roll_w;
    logic [rpw_pkg::TIME_W-1:0] pitch_w;
    logic [rpw_pkg::ACT_W-1:0]  action;

    assign q_now  = q_rdata[TS_W+NCH-1:NCH];
    assign q_mask = q_rdata[NCH-1:0];

    // event load from the queue
    assign load  = (state_reg == ST_IDLE) && !q_empty;
    assign q_pop = load;

    // stage handoff
    assign w_move    = w_valid_reg && (!out_valid_reg || !res_stall);
    assign advance   = !w_valid_reg || w_move;
    assign pick_fire = (state_reg == ST_SCAN) && advance;

    // lowest completing channel
    always_comb
    begin
        logic found;
        found    = 1'b0;
        pick_idx = '0;
        for (int i = 0; i < NCH; i++)
        begin
            if (fall_reg[i] && !found)
            begin
                pick_idx = IDX_W'(i);
                found    = 1'b1;
            end
        end
    end

    assign remaining = fall_reg & ~(NCH'(1) << pick_idx);
    assign pick_last = (remaining == '0);

    // high time with wrap correction, modulo 2^16
    assign rise  = rise_time_reg[pick_idx];
    assign width = ((rise > now_reg) ? cfg.timer_top : '0)
                   + rpw_pkg::TIME_W'(now_reg) - rpw_pkg::TIME_W'(rise);

    // stick decode from stored widths
    assign roll_w  = ({1'b0, cfg.roll_channel} < NCH_V)
                     ? last_width_reg[cfg.roll_channel[IDX_W-1:0]] : '0;
    assign pitch_w = ({1'b0, cfg.pitch_channel} < NCH_V)
                     ? last_width_reg[cfg.pitch_channel[IDX_W-1:0]] : '0;

    always_comb
    begin
        if (roll_w > cfg.upper_threshold)
        begin
            action = rpw_pkg::ACT_RIGHT;
        end
        else if (roll_w < cfg.lower_threshold)
        begin
            action = rpw_pkg::ACT_LEFT;
        end
        else if (pitch_w < cfg.lower_threshold)
        begin
            action = rpw_pkg::ACT_UP;
        end
        else if (pitch_w > cfg.upper_threshold)
        begin
            action = rpw_pkg::ACT_DOWN;
        end
        else
        begin
            action = rpw_pkg::ACT_NONE;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load && ((q_mask & af_reg) != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pick_fire && pick_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // channel state: rises taken at load, falls one per cycle unless the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            af_reg    <= '0;
            fall_reg  <= '0;
            now_reg   <= '0;
            for (int i = 0; i < NCH; i++)
            begin
                rise_time_reg[i]  <= '0;
                last_width_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                now_reg  <= q_now;
                fall_reg <= q_mask & af_reg;
                for (int i = 0; i < NCH; i++)
                begin
                    if (q_mask[i] && !af_reg[i])
                    begin
                        rise_time_reg[i] <= q_now;
                        af_reg[i]        <= 1'b1;
                    end
                end
            end
            else if (pick_fire)
            begin
                fall_reg                 <= remaining;
                af_reg[pick_idx]         <= 1'b0;
                last_width_reg[pick_idx] <= width;
            end
        end
    end

    // width stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pick_fire)
            begin
                w_valid_reg <= 1'b1;
            end
            else if (w_move)
            begin
                w_valid_reg <= 1'b0;
            end
            if (w_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_fire)
        begin
            w_ch_reg    <= rpw_pkg::CH_W'(pick_idx);
            w_width_reg <= width;
            w_last_reg  <= pick_last;
        end
        if (w_move)
        begin
            out_reg.channel      <= w_ch_reg;
            out_reg.pulse_width  <= w_width_reg;
            out_reg.stick_action <= action;
            out_reg.last         <= w_last_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // idle means no completing channel is left over
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fall_reg == '0))
        else $error("completing channels left while idle");

    // only channels in the falling phase are queued for completion
    a_fall_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ((fall_reg & ~af_reg) == '0))
        else $error("completion pending on a channel waiting for rise");

    // a completed channel returns to waiting for the rise
    a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pick_fire |=> !af_reg[$past(pick_idx)])
        else $error("edge phase not cleared after completion");

    // the final completion of an event ends the scan
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_fire && pick_last) |=> (state_reg == ST_IDLE))
        else $error("scan did not end after final completion");

endmodule

/* hdl/rc_pulse_width_capture_stick_action.sv */
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_stick_action
// Pulse width capture for rc receiver channels with stick action decoding.
// ----------------------------------------------------------------------------
// Each evt beat is one timer edge event. The front end masks the pending bits
// with channel_enable and places events that touch an enabled channel in a
// two-entry queue, so a beat is taken as long as the queue has room. The back
// end takes an event from the queue, storing all rising edges at once, then
// completes one falling-edge channel per cycle in ascending order while the
// output is not stalled, and takes the next event only once the last channel
// of the current one is done. Each completed pulse gives one res beat
// carrying the width, the stick action seen after that width was stored, and
// last on the final beat of the event. Events that complete no pulse give no
// beat. The user must write registers only while the block is idle; the
// block itself does not enforce it.
module rc_pulse_width_capture_stick_action #(
    parameter int CHANNELS   = rpw_pkg::CHANNELS_DEF,
    parameter int TIMER_BITS = rpw_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_valid,
    output logic                          evt_stall,
    input  rpw_pkg::evt_t                 evt,
    output logic                          res_valid,
    input  logic                          res_stall,
    output rpw_pkg::res_t                 res,
    input  logic                          cfg_we,
    input  logic [rpw_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [rpw_pkg::CFG_W-1:0]     cfg_data
);

    localparam int NCH  = (CHANNELS < rpw_pkg::MASK_W) ? CHANNELS : rpw_pkg::MASK_W;
    localparam int TS_W = (TIMER_BITS < rpw_pkg::TIME_W) ? TIMER_BITS : rpw_pkg::TIME_W;
    localparam int Q_W  = TS_W + NCH;

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic [Q_W-1:0] q_wdata;
    logic [Q_W-1:0] q_rdata;
    rpw_pkg::cfg_t  cfg;

    // front end: registers and event classification
    rpw_front #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .cfg       (cfg)
    );

    // event queue
    rpw_queue #(
        .WIDTH (Q_W),
        .DEPTH (rpw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // back end: per-channel state and results
    rpw_back #(
        .CHANNELS   (CHANNELS),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
